/* hdl/aes_two_round_diff_histogram_defines.svh */
// Assertion macros used by the block's controller
`ifndef AES_TWO_ROUND_DIFF_HISTOGRAM_DEFINES_SVH
`define AES_TWO_ROUND_DIFF_HISTOGRAM_DEFINES_SVH
// property that must hold while out of reset
`define ATRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked from reset onwards
`define ATRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* hdl/atrd_pkg.sv */
// Package: types, constants and AES helper functions of the block
package atrd_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROUND1,
    ST_ROUND2,
    ST_DIFF,
    ST_RD0,
    ST_RD1,
    ST_INC,
    ST_WR,
    ST_READ_RES,
    ST_OUT
  } state_t;

  localparam logic [2:0] CFG_KEY1_LO = 3'd0;
  localparam logic [2:0] CFG_KEY1_HI = 3'd1;
  localparam logic [2:0] CFG_KEY2_LO = 3'd2;
  localparam logic [2:0] CFG_KEY2_HI = 3'd3;
  localparam logic [2:0] CFG_FILL_LO = 3'd4;
  localparam logic [2:0] CFG_FILL_HI = 3'd5;

  localparam int OUT_W = 41;

  typedef struct packed {
    logic clr_we;     // clearing pass write
    logic load;       // latch item, build plaintexts
    logic round1;
    logic round2;
    logic diff;
    logic rd_addr;    // drive memory read for current lane, or for the requested bin in read mode
    logic rd_latch;   // capture read data
    logic inc;        // compute saturated increment
    logic wr;         // write back and advance lane
    logic read_res;   // build read-mode result
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic last_lane;
    logic clr_done;
  } stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes, ShiftRows, optional MixColumns, AddRoundKey; byte i at [8i+7:8i]
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        t[w + 4*c] = sbox(s[8*(w + 4*((c + w) % 4)) +: 8]);
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = t[i] ^ k[8*i +: 8];
    end
    return r;
  endfunction

endpackage

/* hdl/atrd_in_if.sv */
// Channel interfaces: input items, results and register writes
interface atrd_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] diag_word;
  logic [7:0]  delta;
  logic [1:0]  read_position;
  logic [7:0]  read_bin;
  modport source (output valid, mode, diag_word, delta, read_position, read_bin, input ready);
  modport sink   (input valid, mode, diag_word, delta, read_position, read_bin, output ready);
endinterface

interface atrd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  diff_byte_zero;
  logic [7:0]  diff_byte_thirteen;
  logic [7:0]  diff_byte_ten;
  logic [7:0]  diff_byte_seven;
  logic [40:0] bin_count;
  logic        matches_expected;
  logic [40:0] pairs_total;
  modport source (output valid, diff_byte_zero, diff_byte_thirteen, diff_byte_ten,
                  diff_byte_seven, bin_count, matches_expected, pairs_total, input ready);
  modport sink   (input valid, diff_byte_zero, diff_byte_thirteen, diff_byte_ten,
                  diff_byte_seven, bin_count, matches_expected, pairs_total, output ready);
endinterface

interface atrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/atrd_ctrl.sv */
// Controller: sequences clearing, AES rounds, histogram updates and results
`include "aes_two_round_diff_histogram_defines.svh"
module atrd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           out_fire,
  input  atrd_pkg::stat_t stat,
  output logic           in_ready,
  output atrd_pkg::cmd_t cmd
);
  atrd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= atrd_pkg::ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      atrd_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_done) state_nxt = atrd_pkg::ST_IDLE;
      end
      atrd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = 1'b1;
        if (in_fire) state_nxt = atrd_pkg::ST_ROUND1;
      end
      atrd_pkg::ST_ROUND1: begin
        if (stat.mode) begin
          cmd.rd_addr = 1'b1;
          state_nxt   = atrd_pkg::ST_READ_RES;
        end else begin
          cmd.round1 = 1'b1;
          state_nxt  = atrd_pkg::ST_ROUND2;
        end
      end
      atrd_pkg::ST_ROUND2: begin
        cmd.round2 = 1'b1;
        state_nxt  = atrd_pkg::ST_DIFF;
      end
      atrd_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = atrd_pkg::ST_RD0;
      end
      atrd_pkg::ST_RD0: begin
        cmd.rd_addr = 1'b1;
        state_nxt   = atrd_pkg::ST_RD1;
      end
      atrd_pkg::ST_RD1: begin
        cmd.rd_latch = 1'b1;
        state_nxt    = atrd_pkg::ST_INC;
      end
      atrd_pkg::ST_INC: begin
        cmd.inc   = 1'b1;
        state_nxt = atrd_pkg::ST_WR;
      end
      atrd_pkg::ST_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = stat.last_lane ? atrd_pkg::ST_OUT : atrd_pkg::ST_RD0;
      end
      atrd_pkg::ST_READ_RES: begin
        cmd.read_res = 1'b1;
        state_nxt    = atrd_pkg::ST_OUT;
      end
      atrd_pkg::ST_OUT: begin
        cmd.out_valid = 1'b1;
        if (out_fire) state_nxt = atrd_pkg::ST_IDLE;
      end
      default: state_nxt = atrd_pkg::ST_CLEAR;
    endcase
  end

  `ATRD_ASSERT(a_no_in_while_busy, clk, rst_n, in_fire |-> state_r == atrd_pkg::ST_IDLE, "input taken while busy")
  `ATRD_ASSERT(a_out_only_in_out, clk, rst_n, out_fire |=> state_r == atrd_pkg::ST_IDLE, "result not followed by idle")
  `ATRD_ASSERT(a_load_to_work, clk, rst_n, in_fire |=> state_r == atrd_pkg::ST_ROUND1, "item did not start")
endmodule

/* hdl/atrd_dp.sv */
// Datapath: config registers, AES rounds, histogram memory and counters
module atrd_dp #(
  parameter int COUNT_WIDTH = 41
) (
  input  logic            clk,
  input  logic            rst_n,
  input  atrd_pkg::cmd_t  cmd,
  output atrd_pkg::stat_t stat,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [63:0]     cfg_data,
  input  logic            in_mode,
  input  logic [31:0]     in_diag_word,
  input  logic [7:0]      in_delta,
  input  logic [1:0]      in_read_position,
  input  logic [7:0]      in_read_bin,
  output logic [7:0]      diff_byte_zero,
  output logic [7:0]      diff_byte_thirteen,
  output logic [7:0]      diff_byte_ten,
  output logic [7:0]      diff_byte_seven,
  output logic [40:0]     bin_count,
  output logic            matches_expected,
  output logic [40:0]     pairs_total
);
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  logic [63:0] k1lo_r, k1hi_r, k2lo_r, k2hi_r, flo_r;
  logic [31:0] fhi_r;
  logic [127:0] p1_r, p2_r;
  logic        mode_r;
  logic [1:0]  pos_r;
  logic [7:0]  bin_r;
  logic [31:0] diff_r;
  logic [1:0]  lane_r;
  logic [9:0]  clr_r;
  logic [COUNT_WIDTH-1:0] mem [1024];
  logic [COUNT_WIDTH-1:0] rdata_r, val_r, pairs_r;
  logic [9:0]  raddr, waddr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic        we;
  logic [127:0] pt, pt2;
  logic [7:0]  lane_byte;
  logic [7:0]  d0_r, d13_r, d10_r, d7_r;
  logic [40:0] bin_cnt_r, pairs_o_r;
  logic        match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1lo_r <= '0; k1hi_r <= '0; k2lo_r <= '0; k2hi_r <= '0; flo_r <= '0; fhi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        atrd_pkg::CFG_KEY1_LO: k1lo_r <= cfg_data;
        atrd_pkg::CFG_KEY1_HI: k1hi_r <= cfg_data;
        atrd_pkg::CFG_KEY2_LO: k2lo_r <= cfg_data;
        atrd_pkg::CFG_KEY2_HI: k2hi_r <= cfg_data;
        atrd_pkg::CFG_FILL_LO: flo_r  <= cfg_data;
        atrd_pkg::CFG_FILL_HI: fhi_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // plaintext: diagonal from the item, the rest from the filler registers
  always_comb begin
    pt = {in_diag_word[7:0], fhi_r[31:0], in_diag_word[15:8], flo_r[63:32],
          in_diag_word[23:16], flo_r[31:0], in_diag_word[31:24]};
    pt2 = pt;
    pt2[7:0] = pt[7:0] ^ in_delta;
  end

  always_comb begin
    case (lane_r)
      2'd0:    lane_byte = diff_r[7:0];
      2'd1:    lane_byte = diff_r[15:8];
      2'd2:    lane_byte = diff_r[23:16];
      default: lane_byte = diff_r[31:24];
    endcase
  end

  assign raddr = cmd.rd_addr ? (mode_r ? {pos_r, bin_r} : {lane_r, lane_byte}) : '0;
  assign we    = cmd.clr_we | cmd.wr;
  assign waddr = cmd.clr_we ? clr_r : {lane_r, lane_byte};
  assign wdata = cmd.clr_we ? '0 : val_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      lane_r  <= '0;
      pairs_r <= '0;
    end else begin
      if (cmd.clr_we) clr_r <= clr_r + 10'd1;
      if (cmd.load) lane_r <= '0;
      else if (cmd.wr) lane_r <= lane_r + 2'd1;
      if (cmd.diff && pairs_r != CMAX) pairs_r <= pairs_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p1_r <= pt; p2_r <= pt2;
      mode_r <= in_mode; pos_r <= in_read_position; bin_r <= in_read_bin;
    end
    if (cmd.round1) begin
      p1_r <= atrd_pkg::aes_round(p1_r, {k1hi_r, k1lo_r}, 1'b1);
      p2_r <= atrd_pkg::aes_round(p2_r, {k1hi_r, k1lo_r}, 1'b1);
    end
    if (cmd.round2) begin
      p1_r <= atrd_pkg::aes_round(p1_r, {k2hi_r, k2lo_r}, 1'b0);
      p2_r <= atrd_pkg::aes_round(p2_r, {k2hi_r, k2lo_r}, 1'b0);
    end
    if (cmd.diff) begin
      diff_r <= {p1_r[63:56] ^ p2_r[63:56], p1_r[87:80] ^ p2_r[87:80],
                 p1_r[111:104] ^ p2_r[111:104], p1_r[7:0] ^ p2_r[7:0]};
      d0_r <= p1_r[7:0] ^ p2_r[7:0];
      d13_r <= p1_r[111:104] ^ p2_r[111:104];
      d10_r <= p1_r[87:80] ^ p2_r[87:80];
      d7_r <= p1_r[63:56] ^ p2_r[63:56];
      bin_cnt_r <= '0;
      match_r   <= 1'b0;
    end
    if (cmd.rd_latch) val_r <= rdata_r;
    if (cmd.inc && val_r != CMAX) val_r <= val_r + 1'b1;
    if (cmd.read_res) begin
      d0_r <= '0; d13_r <= '0; d10_r <= '0; d7_r <= '0;
      bin_cnt_r <= 41'(rdata_r);
      match_r   <= (pairs_r[7:0] == 8'd0) &&
                   ({{8{1'b0}}, rdata_r} == {8'd0, pairs_r} >> 8);
    end
    pairs_o_r <= 41'(pairs_r);
  end

  assign stat.mode      = mode_r;
  assign stat.last_lane = (lane_r == 2'd3);
  assign stat.clr_done  = (clr_r == 10'h3FF);

  assign diff_byte_zero     = d0_r;
  assign diff_byte_thirteen = d13_r;
  assign diff_byte_ten      = d10_r;
  assign diff_byte_seven    = d7_r;
  assign bin_count          = bin_cnt_r;
  assign matches_expected   = match_r;
  assign pairs_total        = pairs_o_r;
endmodule

/* hdl/aes_two_round_diff_histogram.sv */
// Top level: two-round AES differential histogram
// Channels: in_* items (valid/ready), out_* results (valid/ready), cfg_* register writes.
// A count item (mode 0) builds two plaintexts differing in byte 0, runs one full and one
// final AES round on both, and returns the differences at bytes 0, 13, 10 and 7 while
// bumping one bin in each of four 256-bin histograms and the pair total, all saturating.
// A read item (mode 1) returns one bin, whether bin*256 equals the total, and the total.
// One item in flight at a time. After transfer, count mode runs the two AES rounds,
// the difference, then per lane a read-modify-write (address, latch, increment, write
// back) of the histogram memory. Read mode reads the bin, then builds the result.
// After the result transfers the block returns to idle and takes the next item.
// Reset: config registers and counters clear; a clearing pass then zeroes all 1024
// histogram entries, during which in_ready stays low (cfg writes are taken).
// A stalled receiver holds the result on out_* and blocks new items until transfer.
module aes_two_round_diff_histogram #(
  parameter int COUNT_WIDTH = 41
) (
  input logic clk,
  input logic rst_n,
  atrd_in_if.sink    in_ch,
  atrd_out_if.source out_ch,
  atrd_cfg_if.sink   cfg_ch
);
  atrd_pkg::cmd_t  cmd;
  atrd_pkg::stat_t stat;
  logic in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = cmd.out_valid;

  atrd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_ch.valid & in_ready),
    .out_fire(cmd.out_valid & out_ch.ready),
    .stat(stat), .in_ready(in_ready), .cmd(cmd)
  );

  atrd_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
    .in_mode(in_ch.mode), .in_diag_word(in_ch.diag_word), .in_delta(in_ch.delta),
    .in_read_position(in_ch.read_position), .in_read_bin(in_ch.read_bin),
    .diff_byte_zero(out_ch.diff_byte_zero), .diff_byte_thirteen(out_ch.diff_byte_thirteen),
    .diff_byte_ten(out_ch.diff_byte_ten), .diff_byte_seven(out_ch.diff_byte_seven),
    .bin_count(out_ch.bin_count), .matches_expected(out_ch.matches_expected),
    .pairs_total(out_ch.pairs_total)
  );
endmodule

/* verif/atrd_tb_pkg.sv */
// Testbench package: transfer structs for items and results
`timescale 1ns / 1ps
package atrd_tb_pkg;
  typedef struct {
    logic        mode;
    logic [31:0] diag_word;
    logic [7:0]  delta;
    logic [1:0]  read_position;
    logic [7:0]  read_bin;
  } pair_item_t;

  typedef struct {
    logic [7:0]  d0;
    logic [7:0]  d13;
    logic [7:0]  d10;
    logic [7:0]  d7;
    logic [40:0] bin_count;
    logic        matches_expected;
    logic [40:0] pairs_total;
  } diff_result_t;
endpackage

/* verif/testbench.sv */
// Testbench top: directed and random checks of the two-round AES differential histogram
`timescale 1ns / 1ps
module testbench;
  localparam int CW = 41;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk;
  logic rst_n;

  atrd_in_if  in_ch ();
  atrd_out_if out_ch ();
  atrd_cfg_if cfg_ch ();

  aes_two_round_diff_histogram #(.COUNT_WIDTH(CW)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor copy of registers and counters
  logic [63:0]   regs [6];
  logic [CW-1:0] hist [4][256];
  logic [CW-1:0] pair_cnt;

  atrd_tb_pkg::diff_result_t expected_q[$];
  int  fail_cnt = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  bit  rx_stall_en = 1'b1;
  bit  tx_gap_en = 1'b1;

  logic [7:0] sb [256];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] gmul2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // state byte i in bits 8i+7:8i
  function automatic logic [127:0] one_round(input logic [127:0] s, input logic [127:0] k,
                                             input bit mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[w + 4*c] = sb[s[8*(w + 4*((c + w) & 3)) +: 8]];
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
        t[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
        t[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
        t[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[8*i +: 8] = t[i] ^ k[8*i +: 8];
    return r;
  endfunction

  function automatic logic [CW-1:0] sat_up(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic atrd_tb_pkg::diff_result_t predict_pair(
      input atrd_tb_pkg::pair_item_t it);
    atrd_tb_pkg::diff_result_t r;
    logic [127:0] k1, k2, p1, p2;
    logic [7:0] fill [12];
    int fpos [12];
    int tpos [4];
    logic [7:0] d [4];
    fpos = '{1, 2, 3, 4, 6, 7, 8, 9, 11, 12, 13, 14};
    tpos = '{0, 13, 10, 7};
    r = '{default: '0};
    if (it.mode) begin
      r.bin_count = hist[it.read_position][it.read_bin];
      r.matches_expected = (pair_cnt[7:0] == 8'd0) &&
                           ({8'd0, pair_cnt[CW-1:8]} == r.bin_count);
      r.pairs_total = pair_cnt;
      return r;
    end
    k1 = {regs[atrd_pkg::CFG_KEY1_HI], regs[atrd_pkg::CFG_KEY1_LO]};
    k2 = {regs[atrd_pkg::CFG_KEY2_HI], regs[atrd_pkg::CFG_KEY2_LO]};
    for (int i = 0; i < 12; i++)
      fill[i] = (i < 8) ? regs[atrd_pkg::CFG_FILL_LO][8*i +: 8]
                        : regs[atrd_pkg::CFG_FILL_HI][8*(i-8) +: 8];
    p1 = '0;
    for (int i = 0; i < 12; i++) p1[8*fpos[i] +: 8] = fill[i];
    p1[7:0]     = it.diag_word[31:24];
    p1[47:40]   = it.diag_word[23:16];
    p1[87:80]   = it.diag_word[15:8];
    p1[127:120] = it.diag_word[7:0];
    p2 = p1;
    p2[7:0] = p2[7:0] ^ it.delta;
    p1 = one_round(one_round(p1, k1, 1'b1), k2, 1'b0);
    p2 = one_round(one_round(p2, k1, 1'b1), k2, 1'b0);
    for (int i = 0; i < 4; i++) begin
      d[i] = p1[8*tpos[i] +: 8] ^ p2[8*tpos[i] +: 8];
      hist[i][d[i]] = sat_up(hist[i][d[i]]);
    end
    pair_cnt = sat_up(pair_cnt);
    r.d0 = d[0]; r.d13 = d[1]; r.d10 = d[2]; r.d7 = d[3];
    r.pairs_total = pair_cnt;
    return r;
  endfunction

  task automatic idle_wait(input int n);
    repeat (n) @(negedge clk);
  endtask

  // valid is dropped only for a gap or by drain, so back-to-back items keep it high
  task automatic send_pair(input atrd_tb_pkg::pair_item_t it);
    int gap;
    gap = tx_gap_en ? int'($urandom_range(0, 19)) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      idle_wait(gap);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= it.mode;
    in_ch.diag_word     <= it.diag_word;
    in_ch.delta         <= it.delta;
    in_ch.read_position <= it.read_position;
    in_ch.read_bin      <= it.read_bin;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_pair(it));
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    idle_wait(25);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == atrd_pkg::CFG_FILL_HI) regs[idx] = {32'd0, val[31:0]};
    else regs[idx] = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic atrd_tb_pkg::pair_item_t count_item(input logic [31:0] dv,
                                                         input logic [7:0] dl);
    atrd_tb_pkg::pair_item_t it;
    it = '{mode: 1'b0, diag_word: dv, delta: dl, read_position: '0, read_bin: '0};
    return it;
  endfunction

  function automatic atrd_tb_pkg::pair_item_t read_item(input logic [1:0] p,
                                                        input logic [7:0] b);
    atrd_tb_pkg::pair_item_t it;
    it = '{mode: 1'b1, diag_word: $urandom, delta: 8'($urandom), read_position: p,
           read_bin: b};
    return it;
  endfunction

  function automatic atrd_tb_pkg::pair_item_t rand_item();
    if ($urandom_range(0, 3) == 0)
      return read_item(2'($urandom), 8'($urandom));
    return count_item($urandom, 8'($urandom));
  endfunction

  task automatic test_directed();
    // zero delta gives zero differences; read on empty histogram
    send_pair(read_item(2'd0, 8'd0));
    send_pair(count_item(32'h0000_0000, 8'h00));
    send_pair(count_item(32'hFFFF_FFFF, 8'hFF));
    send_pair(count_item(32'h0000_0000, 8'h01));
    send_pair(count_item(32'h8000_0001, 8'h80));
    for (int p = 0; p < 4; p++) send_pair(read_item(2'(p), 8'h00));
    send_pair(read_item(2'd3, 8'hFF));
    drain();
    write_reg(atrd_pkg::CFG_KEY1_LO, '1);
    write_reg(atrd_pkg::CFG_KEY1_HI, '1);
    write_reg(atrd_pkg::CFG_KEY2_LO, '1);
    write_reg(atrd_pkg::CFG_KEY2_HI, '1);
    write_reg(atrd_pkg::CFG_FILL_LO, '1);
    write_reg(atrd_pkg::CFG_FILL_HI, '1);
    send_pair(count_item(32'hFFFF_FFFF, 8'h00));
    send_pair(count_item(32'h1234_5678, 8'hA5));
    send_pair(count_item(32'h0000_0000, 8'hFF));
    send_pair(read_item(2'd1, 8'h00));
    drain();
  endtask

  task automatic test_zero_match();
    // pad the total to a multiple of 256 with zero-delta pairs, add 256 more, then read each zero bin
    tx_gap_en = 1'b0;
    while (pair_cnt[7:0] != 8'd0) send_pair(count_item($urandom, 8'h00));
    for (int i = 0; i < 256; i++) send_pair(count_item($urandom, 8'h00));
    tx_gap_en = 1'b1;
    for (int p = 0; p < 4; p++) send_pair(read_item(2'(p), 8'h00));
    drain();
  endtask

  task automatic test_random(input int n);
    for (int ph = 0; ph < 4; ph++) begin
      for (int r = 0; r < 6; r++)
        write_reg(3'(r), (ph == 0) ? 64'd0 : {$urandom, $urandom});
      for (int i = 0; i < n / 4; i++) send_pair(rand_item());
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_pair(rand_item());
    drain();
    wait (!hold_off);
    // sender stops until all results are back
    send_pair(rand_item());
    drain();
  endtask

  // receiver: random stalls, or one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
      if (idle_cycles >= 300) begin
        hold_off    = 1'b0;
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end else if (idle_cycles > 0) begin
      out_ch.ready <= 1'b0;
      idle_cycles--;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_ch.valid && out_ch.ready && rx_stall_en) idle_cycles = $urandom_range(0, 19);
    end
  end

  always @(posedge clk) begin
    atrd_tb_pkg::diff_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no expectation waiting");
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.diff_byte_zero !== e.d0) begin
          $error("diff_byte_zero exp %h got %h", e.d0, out_ch.diff_byte_zero); fail_cnt++;
        end
        if (out_ch.diff_byte_thirteen !== e.d13) begin
          $error("diff_byte_thirteen exp %h got %h", e.d13, out_ch.diff_byte_thirteen);
          fail_cnt++;
        end
        if (out_ch.diff_byte_ten !== e.d10) begin
          $error("diff_byte_ten exp %h got %h", e.d10, out_ch.diff_byte_ten); fail_cnt++;
        end
        if (out_ch.diff_byte_seven !== e.d7) begin
          $error("diff_byte_seven exp %h got %h", e.d7, out_ch.diff_byte_seven); fail_cnt++;
        end
        if (out_ch.bin_count !== e.bin_count) begin
          $error("bin_count exp %h got %h", e.bin_count, out_ch.bin_count); fail_cnt++;
        end
        if (out_ch.matches_expected !== e.matches_expected) begin
          $error("matches_expected exp %b got %b", e.matches_expected,
                 out_ch.matches_expected);
          fail_cnt++;
        end
        if (out_ch.pairs_total !== e.pairs_total) begin
          $error("pairs_total exp %h got %h", e.pairs_total, out_ch.pairs_total);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) sb[i] = atrd_pkg::sbox(8'(i));
    for (int r = 0; r < 6; r++) regs[r] = '0;
    for (int p = 0; p < 4; p++)
      for (int b = 0; b < 256; b++) hist[p][b] = '0;
    pair_cnt     = '0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = 1'b0;
    in_ch.diag_word     = '0;
    in_ch.delta         = '0;
    in_ch.read_position = '0;
    in_ch.read_bin      = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_zero_match();
    test_backpressure();
    test_random(1500);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (expected_q.size() != 0) $error("%0d expected results never came", expected_q.size());
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+hdl
hdl/atrd_pkg.sv
hdl/atrd_in_if.sv
hdl/atrd_ctrl.sv
hdl/atrd_dp.sv
hdl/aes_two_round_diff_histogram.sv
verif/atrd_tb_pkg.sv
verif/testbench.sv
